// ----- hdl/apsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types, codes and the control store of the shortest path sequencer.
// ----------------------------------------------------------------------------
package apsp_pkg;

   localparam int DIST_W = 25;
   localparam int WGT_W  = 16;
   localparam int SRC_W  = 6;
   localparam int VC_W   = 7;
   localparam int STEP_W = 4;

   localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
   localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

   localparam logic [VC_W-1:0] VC_RESET = 7'd64;

   // register select, taken from paddr[2]
   localparam logic REG_VERTEX_COUNT = 1'b0;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_SOLVE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      logic              ok;
      logic [DIST_W-1:0] val;
   } dist_entry_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type ST_CLR   = 4'd0;
   localparam step_type ST_IDLE  = 4'd1;
   localparam step_type ST_LOAD  = 4'd2;
   localparam step_type ST_RD0   = 4'd3;
   localparam step_type ST_RD1   = 4'd4;
   localparam step_type ST_S0    = 4'd5;
   localparam step_type ST_K0    = 4'd6;
   localparam step_type ST_I0    = 4'd7;
   localparam step_type ST_I1    = 4'd8;
   localparam step_type ST_J0    = 4'd9;
   localparam step_type ST_J1    = 4'd10;
   localparam step_type ST_I2    = 4'd11;
   localparam step_type ST_K1    = 4'd12;
   localparam step_type ST_SDONE = 4'd13;

   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_IK   = 2'd1,
      RD_PAIR = 2'd2,
      RD_REQ  = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_CLEAR = 2'd1,
      WR_LOAD  = 2'd2,
      WR_RELAX = 2'd3
   } wr_sel_type;

   typedef enum logic [1:0] {
      CTR_HOLD = 2'd0,
      CTR_ZERO = 2'd1,
      CTR_INC  = 2'd2
   } ctr_op_type;

   typedef enum logic [1:0] {
      EMIT_NONE = 2'd0,
      EMIT_READ = 2'd1,
      EMIT_DONE = 2'd2
   } emit_type;

   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_NEXT     = 3'd1,
      COND_DISPATCH = 3'd2,
      COND_J_MORE   = 3'd3,
      COND_I_MORE   = 3'd4,
      COND_K_MORE   = 3'd5,
      COND_N_ZERO   = 3'd6,
      COND_CLR_MORE = 3'd7
   } cond_type;

   typedef struct packed {
      rd_sel_type rd;
      wr_sel_type wr;
      ctr_op_type k_op;
      ctr_op_type i_op;
      ctr_op_type j_op;
      logic       latch_ik;
      emit_type   emit;
      cond_type   cond;
      step_type   target;
   } ucode_type;

   function automatic step_type op_entry(op_type op);
      step_type s;
      case (op)
         OP_CLEAR: s = ST_CLR;
         OP_LOAD:  s = ST_LOAD;
         OP_SOLVE: s = ST_S0;
         OP_READ:  s = ST_RD0;
         default:  s = ST_IDLE;
      endcase
      return s;
   endfunction

   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      w = '{rd: RD_NONE, wr: WR_NONE, k_op: CTR_HOLD, i_op: CTR_HOLD, j_op: CTR_HOLD,
            latch_ik: 1'b0, emit: EMIT_NONE, cond: COND_NEXT, target: ST_IDLE};
      case (s)
         ST_CLR: begin
            w.wr     = WR_CLEAR;
            w.cond   = COND_CLR_MORE;
            w.target = ST_CLR;
         end
         ST_IDLE: begin
            w.cond = COND_DISPATCH;
         end
         ST_LOAD: begin
            w.wr   = WR_LOAD;
            w.cond = COND_ALWAYS;
         end
         ST_RD0: begin
            w.rd = RD_REQ;
         end
         ST_RD1: begin
            w.emit = EMIT_READ;
            w.cond = COND_ALWAYS;
         end
         ST_S0: begin
            w.k_op   = CTR_ZERO;
            w.cond   = COND_N_ZERO;
            w.target = ST_SDONE;
         end
         ST_K0: begin
            w.i_op = CTR_ZERO;
         end
         ST_I0: begin
            w.rd   = RD_IK;
            w.j_op = CTR_ZERO;
         end
         ST_I1: begin
            w.latch_ik = 1'b1;
         end
         ST_J0: begin
            w.rd = RD_PAIR;
         end
         ST_J1: begin
            w.wr     = WR_RELAX;
            w.j_op   = CTR_INC;
            w.cond   = COND_J_MORE;
            w.target = ST_J0;
         end
         ST_I2: begin
            w.i_op   = CTR_INC;
            w.cond   = COND_I_MORE;
            w.target = ST_I0;
         end
         ST_K1: begin
            w.k_op   = CTR_INC;
            w.cond   = COND_K_MORE;
            w.target = ST_K0;
         end
         ST_SDONE: begin
            w.emit = EMIT_DONE;
            w.cond = COND_ALWAYS;
         end
         default: begin
            w.cond = COND_ALWAYS;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/apsp_dist_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_dist_mem
// Distance matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module apsp_dist_mem #(
   parameter int ADDR_W = 12
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  apsp_pkg::dist_entry_type wr_data,
   input  logic [ADDR_W-1:0]       rd_a_addr,
   input  logic [ADDR_W-1:0]       rd_b_addr,
   output apsp_pkg::dist_entry_type rd_a_data,
   output apsp_pkg::dist_entry_type rd_b_data
);

   localparam int DEPTH = 1 << ADDR_W;

   apsp_pkg::dist_entry_type mem [DEPTH];
   apsp_pkg::dist_entry_type rd_a_ff;
   apsp_pkg::dist_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ----- hdl/apsp_relax.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_relax
// One relaxation step: saturating sum through k and compare with the entry.
// ----------------------------------------------------------------------------
module apsp_relax (
   input  apsp_pkg::dist_entry_type ik,
   input  apsp_pkg::dist_entry_type kj,
   input  apsp_pkg::dist_entry_type ij,
   output logic                     better,
   output logic [apsp_pkg::DIST_W-1:0] sum
);

   logic [apsp_pkg::DIST_W:0] raw;

   always_comb begin
      raw = {ik.val[apsp_pkg::DIST_W-1], ik.val} + {kj.val[apsp_pkg::DIST_W-1], kj.val};
      if (raw[apsp_pkg::DIST_W] != raw[apsp_pkg::DIST_W-1]) begin
         sum = raw[apsp_pkg::DIST_W] ? apsp_pkg::DIST_MIN : apsp_pkg::DIST_MAX;
      end else begin
         sum = raw[apsp_pkg::DIST_W-1:0];
      end
      better = ik.ok && kj.ok && (!ij.ok || ($signed(sum) < $signed(ij.val)));
   end

endmodule

// ----- hdl/apsp_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_sequencer
// Step counter over the control store, loop counters and branch conditions.
// ----------------------------------------------------------------------------
module apsp_sequencer #(
   parameter int CNT_W  = 7,
   parameter int ADDR_W = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  apsp_pkg::op_type        req_op,
   input  logic [CNT_W-1:0]        n_eff,
   output apsp_pkg::ucode_type     ctrl,
   output logic                    busy,
   output logic [CNT_W-1:0]        k_cnt,
   output logic [CNT_W-1:0]        i_cnt,
   output logic [CNT_W-1:0]        j_cnt,
   output logic [ADDR_W-1:0]       clr_cnt
);

   apsp_pkg::step_type upc_ff, upc_in;
   logic [CNT_W-1:0]   k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0]   k_nx, i_nx, j_nx;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               cond_hit;

   function automatic logic [CNT_W-1:0] ctr_next(apsp_pkg::ctr_op_type op,
                                                 logic [CNT_W-1:0] v,
                                                 logic [CNT_W-1:0] nx);
      logic [CNT_W-1:0] r;
      case (op)
         apsp_pkg::CTR_ZERO: r = '0;
         apsp_pkg::CTR_INC:  r = nx;
         default:            r = v;
      endcase
      return r;
   endfunction

   assign ctrl = apsp_pkg::ucode_rom(upc_ff);
   assign k_nx = k_ff + CNT_W'(1);
   assign i_nx = i_ff + CNT_W'(1);
   assign j_nx = j_ff + CNT_W'(1);

   always_comb begin
      case (ctrl.cond)
         apsp_pkg::COND_J_MORE:   cond_hit = (j_nx < n_eff);
         apsp_pkg::COND_I_MORE:   cond_hit = (i_nx < n_eff);
         apsp_pkg::COND_K_MORE:   cond_hit = (k_nx < n_eff);
         apsp_pkg::COND_N_ZERO:   cond_hit = (n_eff == '0);
         apsp_pkg::COND_CLR_MORE: cond_hit = (clr_ff != '1);
         default:                 cond_hit = 1'b0;
      endcase

      case (ctrl.cond)
         apsp_pkg::COND_ALWAYS: begin
            upc_in = ctrl.target;
         end
         apsp_pkg::COND_NEXT: begin
            upc_in = upc_ff + apsp_pkg::STEP_W'(1);
         end
         apsp_pkg::COND_DISPATCH: begin
            upc_in = accept ? apsp_pkg::op_entry(req_op) : upc_ff;
         end
         default: begin
            upc_in = cond_hit ? ctrl.target : upc_ff + apsp_pkg::STEP_W'(1);
         end
      endcase

      k_in   = ctr_next(ctrl.k_op, k_ff, k_nx);
      i_in   = ctr_next(ctrl.i_op, i_ff, i_nx);
      j_in   = ctr_next(ctrl.j_op, j_ff, j_nx);
      clr_in = (ctrl.wr == apsp_pkg::WR_CLEAR) ? clr_ff + ADDR_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= apsp_pkg::ST_CLR;
         k_ff   <= '0;
         i_ff   <= '0;
         j_ff   <= '0;
         clr_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         k_ff   <= k_in;
         i_ff   <= i_in;
         j_ff   <= j_in;
         clr_ff <= clr_in;
      end
   end

   assign busy    = (upc_ff != apsp_pkg::ST_IDLE);
   assign k_cnt   = k_ff;
   assign i_cnt   = i_ff;
   assign j_cnt   = j_ff;
   assign clr_cnt = clr_ff;

endmodule

// ----- hdl/all_pairs_shortest_path.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// Floyd-Warshall distance matrix with clear, load, solve and read requests.
//
// A request is taken on start while busy is low. Clear marks every entry
// unreachable; load writes one edge; read looks up the entry and its
// registered answer shows on rsp_* with rsp_valid. Solve walks k, i, j
// over the first n vertices, n = min(vertex_count, MAX_VERTICES), each
// relaxation being a paired read of d[k][j] and d[i][j], then a write-back
// on the single write port, and ends with a done result.
// Results are single-cycle strobes and cannot be held off by the receiver.
// After reset the matrix is swept clear (busy high); vertex_count resets
// to 64 and is written over the APB port at byte address 0. The user
// must write it only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_operation,
   input  logic [apsp_pkg::SRC_W-1:0]       req_src_vertex,
   input  logic [apsp_pkg::SRC_W-1:0]       req_dst_vertex,
   input  logic signed [apsp_pkg::WGT_W-1:0] req_edge_weight,
   output logic                             rsp_valid,
   output logic                             rsp_result_kind,
   output logic signed [apsp_pkg::DIST_W-1:0] rsp_distance,
   output logic                             rsp_reachable,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [2:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int VW   = $clog2(MAX_VERTICES);
   localparam int CW   = VW + 1;
   localparam int AW   = 2 * VW;
   localparam int NW   = (CW > apsp_pkg::VC_W) ? CW : apsp_pkg::VC_W;
   localparam int CMPW = VW + apsp_pkg::SRC_W + 1;

   logic                           accept;
   apsp_pkg::ucode_type            ctrl;
   logic [CW-1:0]                  k_cnt, i_cnt, j_cnt, n_eff;
   logic [AW-1:0]                  clr_cnt;

   logic [apsp_pkg::SRC_W-1:0]     src_ff, dst_ff;
   logic [apsp_pkg::WGT_W-1:0]     wgt_ff;
   logic [apsp_pkg::VC_W-1:0]      vc_ff, vc_in;

   apsp_pkg::dist_entry_type       ik_ff, ik_in;
   apsp_pkg::dist_entry_type       rd_a_data, rd_b_data, wr_data;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr, rd_a_addr, rd_b_addr, req_addr;
   logic                           in_range;
   logic                           better;
   logic [apsp_pkg::DIST_W-1:0]    sum;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_kind_ff, rsp_kind_in;
   logic [apsp_pkg::DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                           rsp_reach_ff, rsp_reach_in;

   assign accept = start && !busy;

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff <= req_src_vertex;
         dst_ff <= req_dst_vertex;
         wgt_ff <= req_edge_weight;
      end
   end

   // configuration port
   assign pready = 1'b1;
   always_comb begin
      vc_in = vc_ff;
      if (psel && penable && pwrite && (paddr[2] == apsp_pkg::REG_VERTEX_COUNT)) begin
         vc_in = pwdata[apsp_pkg::VC_W-1:0];
      end
      prdata = '0;
      if (paddr[2] == apsp_pkg::REG_VERTEX_COUNT) begin
         prdata = {{(32 - apsp_pkg::VC_W){1'b0}}, vc_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= apsp_pkg::VC_RESET;
      end else begin
         vc_ff <= vc_in;
      end
   end

   assign n_eff = (NW'(vc_ff) > NW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_ff);

   apsp_sequencer #(
      .CNT_W  (CW),
      .ADDR_W (AW)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req_op  (apsp_pkg::op_type'(req_operation)),
      .n_eff   (n_eff),
      .ctrl    (ctrl),
      .busy    (busy),
      .k_cnt   (k_cnt),
      .i_cnt   (i_cnt),
      .j_cnt   (j_cnt),
      .clr_cnt (clr_cnt)
   );

   // address and write selection
   assign in_range = (CMPW'(src_ff) < CMPW'(MAX_VERTICES)) &&
                     (CMPW'(dst_ff) < CMPW'(MAX_VERTICES));
   assign req_addr = {VW'(src_ff), VW'(dst_ff)};

   always_comb begin
      case (ctrl.rd)
         apsp_pkg::RD_IK: begin
            rd_a_addr = {i_cnt[VW-1:0], k_cnt[VW-1:0]};
            rd_b_addr = req_addr;
         end
         apsp_pkg::RD_PAIR: begin
            rd_a_addr = {k_cnt[VW-1:0], j_cnt[VW-1:0]};
            rd_b_addr = {i_cnt[VW-1:0], j_cnt[VW-1:0]};
         end
         default: begin
            rd_a_addr = req_addr;
            rd_b_addr = req_addr;
         end
      endcase

      wr_en   = 1'b0;
      wr_addr = {i_cnt[VW-1:0], j_cnt[VW-1:0]};
      wr_data = '{ok: 1'b1, val: sum};
      case (ctrl.wr)
         apsp_pkg::WR_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt;
            wr_data = '0;
         end
         apsp_pkg::WR_LOAD: begin
            wr_en   = in_range;
            wr_addr = req_addr;
            wr_data = '{ok: 1'b1,
                        val: {{(apsp_pkg::DIST_W - apsp_pkg::WGT_W){wgt_ff[apsp_pkg::WGT_W-1]}},
                              wgt_ff}};
         end
         apsp_pkg::WR_RELAX: begin
            wr_en = better;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   apsp_dist_mem #(
      .ADDR_W (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   apsp_relax u_relax (
      .ik     (ik_ff),
      .kj     (rd_a_data),
      .ij     (rd_b_data),
      .better (better),
      .sum    (sum)
   );

   // d[i][k] is held across the j loop; refresh it when j hits k
   always_comb begin
      ik_in = ik_ff;
      if (ctrl.latch_ik) begin
         ik_in = rd_a_data;
      end else if ((ctrl.wr == apsp_pkg::WR_RELAX) && better && (j_cnt == k_cnt)) begin
         ik_in = '{ok: 1'b1, val: sum};
      end
   end

   always_ff @(posedge clock) begin
      ik_ff <= ik_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = (ctrl.emit != apsp_pkg::EMIT_NONE);
      rsp_kind_in  = apsp_pkg::KIND_READ;
      rsp_dist_in  = '0;
      rsp_reach_in = 1'b0;
      case (ctrl.emit)
         apsp_pkg::EMIT_DONE: begin
            rsp_kind_in = apsp_pkg::KIND_DONE;
         end
         apsp_pkg::EMIT_READ: begin
            if (!in_range) begin
               rsp_reach_in = 1'b0;
            end else if (src_ff == dst_ff) begin
               rsp_reach_in = 1'b1;
            end else if (rd_b_data.ok) begin
               rsp_dist_in  = rd_b_data.val;
               rsp_reach_in = 1'b1;
            end
         end
         default: begin
            rsp_kind_in = apsp_pkg::KIND_READ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_reach_ff <= rsp_reach_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_reachable   = rsp_reach_ff;

`ifndef SYNTHESIS
   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not start the sequencer");

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> busy)
      else $error("clearing pass not started after reset");

   a_done_payload : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == apsp_pkg::KIND_DONE)) |->
      (!rsp_reachable && (rsp_distance == '0)))
      else $error("solve done result carries a distance");
`endif

endmodule
